// ===== sv/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// shared constants, types and tables of the line position centroid block
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  // default geometry
  localparam int LPC_CHANNELS    = 8;
  localparam int LPC_SAMPLE_BITS = 12;

  // fixed by the sensor bar and the result format
  localparam int NUM_CH_MAX  = 8;
  localparam int WEIGHT_W    = 13;
  localparam int POS_W       = 13;
  localparam int QUO_W       = 12;
  localparam int CFG_IDX_W   = 4;
  localparam int MASK_W      = 8;
  localparam int FLAT_MARGIN = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } lpc_state_e;

  typedef struct packed {
    logic start;
    logic neg;
  } lpc_div_ctrl_t;

  typedef struct packed {
    logic                    done;
    logic signed [POS_W-1:0] quotient;
  } lpc_div_stat_t;

  // position weight of each channel, leftmost first
  function automatic logic signed [WEIGHT_W-1:0] chan_weight(input logic [2:0] idx);
    logic signed [WEIGHT_W-1:0] w;
    case (idx)
      3'd0:    w = -13'sd3500;
      3'd1:    w = -13'sd2500;
      3'd2:    w = -13'sd1500;
      3'd3:    w = -13'sd500;
      3'd4:    w = 13'sd500;
      3'd5:    w = 13'sd1500;
      3'd6:    w = 13'sd2500;
      3'd7:    w = 13'sd3500;
      default: w = 13'sd0;
    endcase
    return w;
  endfunction

  // threshold values after reset
  function automatic logic [15:0] thr_reset(input int idx);
    logic [15:0] v;
    case (idx)
      0:       v = 16'd1042;
      1:       v = 16'd1535;
      2:       v = 16'd1919;
      3:       v = 16'd772;
      4:       v = 16'd914;
      5:       v = 16'd2140;
      6:       v = 16'd2682;
      7:       v = 16'd2088;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lpc_divider.sv =====
// ----------------------------------------------------------------------------
// lpc_divider
// restoring divider, one quotient bit per cycle, signed result
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_divider #(
  parameter int CHANNELS    = lpc_pkg::LPC_CHANNELS,
  parameter int SAMPLE_BITS = lpc_pkg::LPC_SAMPLE_BITS
) (
  input  wire                                                  clk_i,
  input  wire                                                  rst_ni,
  input  lpc_pkg::lpc_div_ctrl_t                               ctrl_i,
  input  wire [SAMPLE_BITS+lpc_pkg::QUO_W+$clog2(CHANNELS)-1:0] num_i,
  input  wire [SAMPLE_BITS+$clog2(CHANNELS)-1:0]               den_i,
  output lpc_pkg::lpc_div_stat_t                               stat_o
);
  import lpc_pkg::*;

  localparam int L_W    = $clog2(CHANNELS);
  localparam int TOT_W  = SAMPLE_BITS + L_W;
  localparam int NUM_W  = SAMPLE_BITS + QUO_W + L_W;
  localparam int DVS_W  = TOT_W + QUO_W - 1;
  localparam int CNT_W  = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [NUM_W-1:0] dvs_ext;
  logic             fits;

  assign dvs_ext = NUM_W'(dvs_q);
  assign fits    = (rem_q >= dvs_ext);

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d  = num_i;
      dvs_d  = {den_i, {(QUO_W-1){1'b0}}};
      quo_d  = '0;
      cnt_d  = CNT_W'(QUO_W - 1);
      busy_d = 1'b1;
      neg_d  = ctrl_i.neg;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dvs_ext;
      end
      quo_d = {quo_q[QUO_W-2:0], fits};
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  always_comb begin
    stat_o.done     = done_q;
    stat_o.quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  end

endmodule

`default_nettype wire

// ===== sv/line_position_centroid_top.sv =====
// ----------------------------------------------------------------------------
// line_position_centroid_top
// weighted centroid line position from one frame of reflectance samples
// ----------------------------------------------------------------------------
// One transaction on the input carries a frame of CHANNELS samples; each
// frame gives exactly one result transaction with the line position and the
// mask of dark channels. A frame runs the centroid pass (one channel per
// cycle through a rotating sample register and a single multiply-accumulate),
// a decision state and the bit-serial divider, then capture and result. A
// frame with no channel under its threshold and enough contrast runs a
// second pass around the mid level; a flat frame ends after the first pass.
// Thresholds are written through cfg_we_i / cfg_index_i / cfg_data_i; the
// user must write them only while the block is idle, which the block itself
// does not enforce; indexes at or above CHANNELS are ignored.
`default_nettype none

module line_position_centroid_top #(
  parameter int CHANNELS    = lpc_pkg::LPC_CHANNELS,
  parameter int SAMPLE_BITS = lpc_pkg::LPC_SAMPLE_BITS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               cfg_we_i,
  input  wire [lpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [SAMPLE_BITS-1:0]             cfg_data_i,
  // frame input
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire [SAMPLE_BITS-1:0]             sample_0_i,
  input  wire [SAMPLE_BITS-1:0]             sample_1_i,
  input  wire [SAMPLE_BITS-1:0]             sample_2_i,
  input  wire [SAMPLE_BITS-1:0]             sample_3_i,
  input  wire [SAMPLE_BITS-1:0]             sample_4_i,
  input  wire [SAMPLE_BITS-1:0]             sample_5_i,
  input  wire [SAMPLE_BITS-1:0]             sample_6_i,
  input  wire [SAMPLE_BITS-1:0]             sample_7_i,
  // result output
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [lpc_pkg::POS_W-1:0]  position_error_o,
  output logic [lpc_pkg::MASK_W-1:0]        hit_mask_o
);
  import lpc_pkg::*;

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int TOT_W  = SAMPLE_BITS + CH_W;
  localparam int NUM_W  = SAMPLE_BITS + QUO_W + CH_W;
  localparam int WS_W   = NUM_W + 1;
  localparam int INT_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = INT_W + WEIGHT_W;

  // input samples as an array
  logic [SAMPLE_BITS-1:0] in_smp [NUM_CH_MAX];
  assign in_smp[0] = sample_0_i;
  assign in_smp[1] = sample_1_i;
  assign in_smp[2] = sample_2_i;
  assign in_smp[3] = sample_3_i;
  assign in_smp[4] = sample_4_i;
  assign in_smp[5] = sample_5_i;
  assign in_smp[6] = sample_6_i;
  assign in_smp[7] = sample_7_i;

  // control state
  lpc_state_e state_q, state_d;
  logic       pass2_q;
  logic       out_valid_q;

  // datapath registers
  logic [SAMPLE_BITS-1:0]  thr_q [CHANNELS];
  logic [SAMPLE_BITS-1:0]  smp_q [CHANNELS];
  logic [CH_W-1:0]         ch_q;
  logic signed [WS_W-1:0]  wsum_q;
  logic [TOT_W-1:0]        tot_q;
  logic [CHANNELS-1:0]     mask_q;
  logic [SAMPLE_BITS-1:0]  lo_q, hi_q;
  logic [SAMPLE_BITS-1:0]  mid_q;
  logic signed [POS_W-1:0] last_pos_q;
  logic signed [POS_W-1:0] pos_out_q;
  logic [MASK_W-1:0]       mask_out_q;

  // control outputs of the sequencer
  logic          accept;
  logic          pass_last;
  logic          start_pass2;
  logic          load_out;
  logic          flat_contrast;
  lpc_div_ctrl_t div_ctrl;
  lpc_div_stat_t div_stat;

  // datapath of one channel step
  logic [SAMPLE_BITS-1:0]   pivot;
  logic signed [INT_W-1:0]  inten;
  logic                     dark;
  logic signed [PROD_W-1:0] prod;
  logic [INT_W-1:0]         lo_margin;
  logic [INT_W-1:0]         lo_hi_sum;
  logic signed [WS_W-1:0]   wsum_neg;
  logic [NUM_W-1:0]         num_mag;

  assign pivot     = pass2_q ? mid_q : thr_q[ch_q];
  assign inten     = $signed({1'b0, pivot}) - $signed({1'b0, smp_q[0]});
  assign dark      = !inten[INT_W-1] && (inten != '0);
  assign prod      = PROD_W'(inten) * PROD_W'(chan_weight(3'(ch_q)));
  assign pass_last = (ch_q == CH_W'(CHANNELS - 1));

  // contrast test for a frame with no dark channel
  assign lo_margin     = {1'b0, lo_q} + INT_W'(FLAT_MARGIN);
  assign flat_contrast = ({1'b0, hi_q} > lo_margin);
  assign lo_hi_sum     = {1'b0, lo_q} + {1'b0, hi_q};

  // divide magnitudes; the divider puts the sign back
  assign wsum_neg = -wsum_q;
  assign num_mag  = wsum_q[WS_W-1] ? wsum_neg[NUM_W-1:0] : wsum_q[NUM_W-1:0];

  lpc_divider #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (num_mag),
    .den_i  (tot_q),
    .stat_o (div_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        if (pass_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (tot_q != '0) begin
          state_d = ST_DIV;
        end else if (!pass2_q && flat_contrast) begin
          state_d = ST_PASS;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o     = 1'b0;
    start_pass2    = 1'b0;
    load_out       = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.neg   = wsum_q[WS_W-1];
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_CHECK: begin
        if (tot_q != '0) begin
          div_ctrl.start = 1'b1;
        end else if (!pass2_q && flat_contrast) begin
          start_pass2 = 1'b1;
        end
      end
      ST_OUT:   load_out = !out_valid_q || out_ready_i;
      default:  in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
      last_pos_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        thr_q[i] <= SAMPLE_BITS'(thr_reset(i));
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        pass2_q <= 1'b0;
      end else if (start_pass2) begin
        pass2_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // only a successful pass moves the held position
      if (div_stat.done) begin
        last_pos_q <= div_stat.quotient;
      end
      if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(CHANNELS))) begin
        thr_q[cfg_index_i[CH_W-1:0]] <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept || start_pass2) begin
      ch_q   <= '0;
      wsum_q <= '0;
      tot_q  <= '0;
      mask_q <= '0;
    end else if (state_q == ST_PASS) begin
      ch_q <= ch_q + CH_W'(1);
      if (dark) begin
        wsum_q       <= wsum_q + WS_W'(prod);
        tot_q        <= tot_q + TOT_W'(inten[SAMPLE_BITS-1:0]);
        mask_q[ch_q] <= 1'b1;
      end
    end

    // sample register rotates one channel per cycle, back in place after a pass
    if (accept) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smp_q[i] <= in_smp[i];
      end
    end else if (state_q == ST_PASS) begin
      for (int i = 0; i < CHANNELS - 1; i++) begin
        smp_q[i] <= smp_q[i+1];
      end
      smp_q[CHANNELS-1] <= smp_q[0];
    end

    // frame minimum and maximum, gathered during the first pass
    if (state_q == ST_PASS && !pass2_q) begin
      if (ch_q == '0) begin
        lo_q <= smp_q[0];
        hi_q <= smp_q[0];
      end else begin
        if (smp_q[0] < lo_q) begin
          lo_q <= smp_q[0];
        end
        if (smp_q[0] > hi_q) begin
          hi_q <= smp_q[0];
        end
      end
    end

    if (start_pass2) begin
      mid_q <= lo_hi_sum[INT_W-1:1];
    end

    if (load_out) begin
      pos_out_q  <= div_stat.done ? div_stat.quotient : last_pos_q;
      mask_out_q <= MASK_W'(mask_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_error_o = pos_out_q;
  assign hit_mask_o       = mask_out_q;

endmodule

`default_nettype wire

// ===== verif/line_position_centroid_top_tb.sv =====
// ----------------------------------------------------------------------------
// line_position_centroid_top_tb
// self-checking bench for the weighted centroid line position block
// ----------------------------------------------------------------------------
// Frames go in through the input handshake and positions come back through
// the output handshake. A scoreboard class predicts each position and mask
// from the thresholds it has seen written. Both handshakes idle at random,
// and the thresholds move through reset values, all zero, all full scale
// and several random settings.
`timescale 1ns / 100ps

module line_position_centroid_top_tb;
  import lpc_pkg::*;

  localparam int NCH = LPC_CHANNELS;
  localparam int SW  = LPC_SAMPLE_BITS;

  // register map: one threshold per channel, the rest of the index space unused
  localparam int REG_THR_CH0      = 0;
  localparam int REG_UNUSED_FIRST = NCH;

  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef logic [SW-1:0]                sample_t;
  typedef logic [NCH-1:0][SW-1:0]       frame_t;
  typedef logic signed [POS_W-1:0]      pos_t;
  typedef logic [MASK_W-1:0]            mask_t;
  typedef struct packed {
    pos_t  position;
    mask_t mask;
  } centroid_t;

  localparam sample_t MAX_S = '1;
  // threshold values after reset, channel 7 first
  localparam frame_t DEFAULT_THR = {12'd2088, 12'd2682, 12'd2140, 12'd914,
                                    12'd772, 12'd1919, 12'd1535, 12'd1042};

  // --------------------------------------------------------------------------
  // scoreboard: predicts one position per frame and checks results in order
  // --------------------------------------------------------------------------
  class centroid_scoreboard;
    frame_t      thr;
    pos_t        held_pos;
    centroid_t   pending_positions[$];
    int unsigned mismatches;
    int unsigned n_checked;
    int unsigned n_dark_frames;
    int unsigned n_recentered;
    int unsigned n_flat;

    function new();
      thr           = DEFAULT_THR;
      held_pos      = '0;
      mismatches    = 0;
      n_checked     = 0;
      n_dark_frames = 0;
      n_recentered  = 0;
      n_flat        = 0;
    endfunction

    function void set_threshold(int idx, sample_t val);
      // writes beyond the last channel have no effect
      if (idx < NCH) thr[idx] = val;
    endfunction

    function int pending();
      return pending_positions.size();
    endfunction

    // one centroid pass against per-channel levels, 1 when any channel is dark
    function bit centroid_pass(input frame_t smp, input frame_t lvl,
                               output pos_t pos, output mask_t mask);
      int wsum;
      int isum;
      int inten;
      wsum = 0;
      isum = 0;
      mask = '0;
      pos  = '0;
      for (int i = 0; i < NCH; i++) begin
        inten = int'(lvl[i]) - int'(smp[i]);
        if (inten > 0) begin
          // weights run -3500 .. 3500 in steps of 1000
          wsum    += inten * (1000 * i - 3500);
          isum    += inten;
          mask[i] = 1'b1;
        end
      end
      if (isum == 0) return 1'b0;
      pos = pos_t'(wsum / isum);
      return 1'b1;
    endfunction

    function void note_frame(frame_t smp);
      frame_t      lvl;
      pos_t        pos;
      mask_t       mask;
      int unsigned lo;
      int unsigned hi;
      centroid_t   res;
      if (centroid_pass(smp, thr, pos, mask)) begin
        held_pos = pos;
        n_dark_frames++;
      end else begin
        lo = 32'(smp[0]);
        hi = 32'(smp[0]);
        for (int i = 1; i < NCH; i++) begin
          if (smp[i] < lo) lo = 32'(smp[i]);
          if (smp[i] > hi) hi = 32'(smp[i]);
        end
        mask = '0;
        if (hi > lo + FLAT_MARGIN) begin
          // second pass around the mid level of the frame
          for (int i = 0; i < NCH; i++) lvl[i] = sample_t'((lo + hi) / 2);
          if (centroid_pass(smp, lvl, pos, mask)) held_pos = pos;
          n_recentered++;
        end else begin
          n_flat++;
        end
      end
      res.position = held_pos;
      res.mask     = mask;
      pending_positions.push_back(res);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(pos_t pos, mask_t mask);
      centroid_t want;
      n_checked++;
      if (pending_positions.size() == 0) begin
        report($sformatf("result %0d unexpected: position %0d mask %02h",
                         n_checked, pos, mask));
        return;
      end
      want = pending_positions.pop_front();
      if (pos !== want.position)
        report($sformatf("result %0d position %0d, predicted %0d",
                         n_checked, pos, want.position));
      if (mask !== want.mask)
        report($sformatf("result %0d hit mask %02h, predicted %02h",
                         n_checked, mask, want.mask));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                    clk_i;
  logic                    rst_ni     = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  sample_t                 cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  frame_t                  sample_bus = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  pos_t                    position_error;
  mask_t                   hit_mask;

  centroid_scoreboard centroids;

  // bench controls shared between the sender and the receiver
  bit          steady_mode   = 1'b0;   // no idling on either side
  bit          sink_hold_req = 1'b0;   // ask the receiver for a long hold-off
  int unsigned n_holds       = 0;
  int unsigned n_settings    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  line_position_centroid_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .sample_0_i       (sample_bus[0]),
    .sample_1_i       (sample_bus[1]),
    .sample_2_i       (sample_bus[2]),
    .sample_3_i       (sample_bus[3]),
    .sample_4_i       (sample_bus[4]),
    .sample_5_i       (sample_bus[5]),
    .sample_6_i       (sample_bus[6]),
    .sample_7_i       (sample_bus[7]),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .position_error_o (position_error),
    .hit_mask_o       (hit_mask)
  );

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random frame shaped against the current thresholds
  function automatic frame_t random_frame(input frame_t thr);
    frame_t      f;
    int unsigned kind;
    int unsigned c;
    int unsigned w;
    int unsigned peak;
    int unsigned base;
    int unsigned v;
    kind = $urandom_range(0, 99);
    c    = $urandom_range(0, NCH - 1);
    w    = $urandom_range(1, 3);
    peak = 0;
    for (int i = 0; i < NCH; i++) if (thr[i] > peak) peak = 32'(thr[i]);
    base = (peak > MAX_S - FLAT_MARGIN) ? peak : $urandom_range(peak, MAX_S - FLAT_MARGIN);
    for (int i = 0; i < NCH; i++) begin
      if (kind < 50) begin
        // a line under a few neighboring channels, bright floor elsewhere
        if (i >= c && i < c + w && thr[i] != 0)
          f[i] = sample_t'($urandom_range(0, thr[i] - 1));
        else f[i] = sample_t'($urandom_range(thr[i], MAX_S));
      end else if (kind < 65) begin
        // nothing under threshold, contrast decides the pivot pass
        f[i] = sample_t'($urandom_range(thr[i], MAX_S));
      end else if (kind < 75) begin
        // flat bright frame within the margin
        v    = base + $urandom_range(0, FLAT_MARGIN);
        f[i] = (v > MAX_S) ? MAX_S : sample_t'(v);
      end else begin
        f[i] = sample_t'($urandom_range(0, MAX_S));
      end
    end
    return f;
  endfunction

  // offer one frame after an idle gap and hold it until accepted
  task automatic send_frame(input frame_t smp, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid   <= 1'b1;
    sample_bus <= smp;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    centroids.note_frame(smp);
  endtask

  // stop offering and wait for every predicted result
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (centroids.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // write all thresholds, each preceded by a write to an unused index
  task automatic load_thresholds(input frame_t thr);
    sample_t junk;
    for (int i = 0; i < NCH; i++) begin
      junk = sample_t'($urandom);
      @(negedge clk_i);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(REG_UNUSED_FIRST + i);
      cfg_data  <= junk;
      centroids.set_threshold(REG_UNUSED_FIRST + i, junk);
      @(negedge clk_i);
      cfg_index <= CFG_IDX_W'(REG_THR_CH0 + i);
      cfg_data  <= thr[i];
      centroids.set_threshold(REG_THR_CH0 + i, thr[i]);
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // random frames with steady stretches, one long output hold-off and
  // periodic pauses until the block has drained
  task automatic run_random(input int unsigned count);
    for (int n = 0; n < count; n++) begin
      steady_mode = ((n / 50) % 6 == 5);
      if (n == count / 3) begin
        sink_hold_req = 1'b1;
        n_holds++;
      end
      send_frame(random_frame(centroids.thr), pick_idle());
      if (n % 200 == 199) settle();
    end
    steady_mode = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  // check every result transaction at the edge that accepts it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) centroids.check_result(position_error, hit_mask);
  end

  // cycle counter, ends a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles,
             centroids.pending());
    $display("line_position_centroid_top_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    frame_t f;
    frame_t thr;
    centroids = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // reset thresholds, directed frames
    f = {NCH{MAX_S}};                         // bright and flat: held zero
    send_frame(f, 0);
    f = '0;                                   // every channel dark
    send_frame(f, pick_idle());
    f = {NCH{MAX_S}}; f[0] = '0;              // leftmost alone
    send_frame(f, pick_idle());
    f = {NCH{MAX_S}}; f[NCH-1] = '0;          // rightmost alone
    send_frame(f, pick_idle());
    f = DEFAULT_THR;                          // samples on threshold are not dark
    send_frame(f, pick_idle());
    f = {NCH{sample_t'(3000)}}; f[5] = sample_t'(3040);  // spread right at the margin
    send_frame(f, pick_idle());
    f[5] = sample_t'(3000); f[2] = sample_t'(3041);      // one above, pivot pass
    send_frame(f, pick_idle());
    f = {NCH{MAX_S}};                         // negative quotient truncates up
    f[0] = sample_t'(DEFAULT_THR[0] - 1); f[1] = sample_t'(DEFAULT_THR[1] - 2);
    send_frame(f, pick_idle());
    f = {NCH{MAX_S}};                         // balanced center pair
    f[3] = sample_t'(DEFAULT_THR[3] - 1); f[4] = sample_t'(DEFAULT_THR[4] - 1);
    send_frame(f, pick_idle());
    f = {NCH{MAX_S}}; f[3] = '0; f[4] = '0;   // unequal center pair
    send_frame(f, pick_idle());
    f = {NCH{MAX_S}};                         // neighbor on threshold ignored
    f[0] = DEFAULT_THR[0]; f[1] = sample_t'(DEFAULT_THR[1] - 1);
    send_frame(f, pick_idle());
    f = {NCH{MAX_S}};                         // flat again keeps the last position
    send_frame(f, pick_idle());
    f[6] = DEFAULT_THR[6];                    // pivot pass finds one channel
    send_frame(f, pick_idle());
    for (int i = 0; i < NCH; i++) f[i] = sample_t'(DEFAULT_THR[i] - 1);  // all just dark
    send_frame(f, pick_idle());
    run_random(300);

    // zero thresholds: nothing is ever dark, every frame with enough contrast takes the slow path
    settle();
    load_thresholds('0);
    f = '0;
    send_frame(f, 0);
    f = {NCH{MAX_S}}; f[0] = '0;
    send_frame(f, pick_idle());
    f = '0; f[NCH-1] = MAX_S;
    send_frame(f, pick_idle());
    run_random(150);

    // full-scale thresholds
    settle();
    load_thresholds({NCH{MAX_S}});
    f = {NCH{MAX_S}};
    send_frame(f, 0);
    f = {NCH{sample_t'(MAX_S - 1)}};
    send_frame(f, pick_idle());
    run_random(150);

    // random settings, the first over the full range
    for (int p = 0; p < 4; p++) begin
      settle();
      for (int i = 0; i < NCH; i++)
        thr[i] = (p == 0) ? sample_t'($urandom_range(0, MAX_S))
                          : sample_t'($urandom_range(400, 3600));
      load_thresholds(thr);
      run_random(250);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("checked %0d results: %0d with dark channels, %0d re-centered, %0d flat",
             centroids.n_checked, centroids.n_dark_frames, centroids.n_recentered,
             centroids.n_flat);
    $display("%0d threshold settings after reset, %0d long output hold-offs",
             n_settings, n_holds);
    if (centroids.mismatches == 0 && centroids.pending() == 0) begin
      $display("line_position_centroid_top_tb OK");
    end else begin
      $display("line_position_centroid_top_tb NOT OK");
    end
    $finish;
  end

endmodule
